// ===== src/lldm_pkg.sv =====
// Package for the least-loaded drone makespan unit.
// Field widths, stream packing offsets and saturation limits.
// No dependencies; used by the top level and the port checker.
package lldm_pkg;

    // Field widths
    localparam int unsigned ID_W    = 6;
    localparam int unsigned COORD_W = 6;
    localparam int unsigned DRONE_W = 2;
    localparam int unsigned COST_W  = 7;
    localparam int unsigned SUM_W   = 14;

    // Square root datapath: operand of the shared squarer and its product
    localparam int unsigned ROOT_W  = 7;
    localparam int unsigned PROD_W  = 2 * ROOT_W;
    localparam int unsigned BIT_W   = 3;

    // Saturation limits
    localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};
    localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

    // Input tdata packing, lowest bit first
    localparam int unsigned S_ID_LSB  = 0;
    localparam int unsigned S_CX_LSB  = S_ID_LSB + ID_W;
    localparam int unsigned S_CY_LSB  = S_CX_LSB + COORD_W;
    localparam int unsigned S_SX_LSB  = S_CY_LSB + COORD_W;
    localparam int unsigned S_SY_LSB  = S_SX_LSB + COORD_W;
    localparam int unsigned S_USED_W  = S_SY_LSB + COORD_W;
    localparam int unsigned S_TDATA_W = ((S_USED_W + 7) / 8) * 8;

    // Output tdata packing, lowest bit first
    localparam int unsigned M_ID_LSB    = 0;
    localparam int unsigned M_DRONE_LSB = M_ID_LSB + ID_W;
    localparam int unsigned M_COST_LSB  = M_DRONE_LSB + DRONE_W;
    localparam int unsigned M_SPAN_LSB  = M_COST_LSB + COST_W;
    localparam int unsigned M_SCORE_LSB = M_SPAN_LSB + SUM_W;
    localparam int unsigned M_USED_W    = M_SCORE_LSB + SUM_W;
    localparam int unsigned M_TDATA_W   = ((M_USED_W + 7) / 8) * 8;

endpackage

// ===== src/least_loaded_drone_makespan_unit.sv =====
// Least-loaded drone makespan unit: top level.
// One customer per input transfer; uses lldm_pkg for widths and packing.
// Assigns each customer to the least loaded drone and tracks stop makespans.
//
// Each input transfer is one customer at a stop. The unit computes the trip
// cost as the ceiling of the customer-to-stop distance, hands the customer
// to the drone with the smallest load (lowest index on a tie), and adds the
// cost to that load; all sums saturate at 16383. On the last customer of a
// stop (s_tuser) it reports the largest load and adds it to the score; on the
// last customer of a batch (s_tlast) it reports the score and clears it. One
// result transfer follows each input transfer. The unit takes one customer
// at a time; the shared 7x7 squarer forms dx*dx and dy*dy and then resolves
// the square root one bit per cycle, and the load scan runs alongside. A
// customer that closes a stop adds a makespan scan over the loads. A new
// customer is taken while the previous result still waits.
module least_loaded_drone_makespan_unit #(
    parameter int NUM_DRONES = 3,
    parameter int COORD_MAX  = 63
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // s_tdata: customer_id, cust_x, cust_y, site_x, site_y, zero pad
    input  logic [lldm_pkg::S_TDATA_W-1:0] s_tdata,
    // s_tuser: last_in_stop
    input  logic                           s_tuser,
    input  logic                           s_tlast,   // last_in_batch
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // m_tdata: assigned_customer, drone_index, trip_cost, stop_makespan,
    //          total_score, zero pad
    output logic [lldm_pkg::M_TDATA_W-1:0] m_tdata,
    // m_tuser: stop_done
    output logic                           m_tuser,
    output logic                           m_tlast,   // batch_done
    output logic                           m_tvalid,
    input  logic                           m_tready
);

    localparam int IDX_W = (NUM_DRONES > 1) ? $clog2(NUM_DRONES) : 1;
    localparam int CNT_W = $clog2(NUM_DRONES + 1);
    localparam logic [CNT_W-1:0] CNT_END = CNT_W'(NUM_DRONES);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQX,
        ST_SQY,
        ST_ROOT,
        ST_CEIL,
        ST_ADD,
        ST_MAX,
        ST_EMIT
    } state_t;

    typedef logic [lldm_pkg::SUM_W-1:0] sum_t;

    state_t                          state_reg, state_next;
    logic [lldm_pkg::ID_W-1:0]       cid_reg, cid_next;
    logic [lldm_pkg::COORD_W-1:0]    dx_reg, dx_next;
    logic [lldm_pkg::COORD_W-1:0]    dy_reg, dy_next;
    logic                            stop_reg, stop_next;
    logic                            batch_reg, batch_next;
    logic [lldm_pkg::PROD_W-1:0]     sq_reg, sq_next;
    logic [lldm_pkg::ROOT_W-1:0]     root_reg, root_next;
    logic [lldm_pkg::BIT_W-1:0]      bit_reg, bit_next;
    logic [lldm_pkg::COST_W-1:0]     cost_reg, cost_next;
    logic [CNT_W-1:0]                scan_reg, scan_next;
    sum_t                            best_reg, best_next;
    logic [IDX_W-1:0]                pick_reg, pick_next;
    sum_t                            max_reg, max_next;
    sum_t                            load_reg [NUM_DRONES];
    sum_t                            load_next [NUM_DRONES];
    sum_t                            score_reg, score_next;
    logic                            m_valid_reg, m_valid_next;
    logic [lldm_pkg::M_TDATA_W-1:0]  m_data_reg, m_data_next;
    logic                            m_user_reg, m_user_next;
    logic                            m_last_reg, m_last_next;

    logic [lldm_pkg::COORD_W-1:0]    in_cx, in_cy, in_sx, in_sy;
    logic [lldm_pkg::ROOT_W-1:0]     mul_a;
    logic [lldm_pkg::PROD_W-1:0]     mul_p;
    logic [lldm_pkg::ROOT_W-1:0]     trial;
    logic [lldm_pkg::ROOT_W:0]       root_inc;
    logic [IDX_W-1:0]                rd_idx;
    sum_t                            rd_load;
    logic [lldm_pkg::SUM_W:0]        add_sum;
    sum_t                            add_a, add_b, add_sat;
    logic                            scan_live;
    logic                            out_free;
    logic [3:0]                      pick_ext;

    function automatic logic [lldm_pkg::COORD_W-1:0] clamp(
        input logic [lldm_pkg::COORD_W-1:0] v
    );
        return (int'(v) > COORD_MAX) ? lldm_pkg::COORD_W'(COORD_MAX) : v;
    endfunction

    function automatic logic [lldm_pkg::COORD_W-1:0] abs_diff(
        input logic [lldm_pkg::COORD_W-1:0] a,
        input logic [lldm_pkg::COORD_W-1:0] b
    );
        return (a >= b) ? (a - b) : (b - a);
    endfunction

    // Input field unpacking and clamping
    assign in_cx = clamp(s_tdata[lldm_pkg::S_CX_LSB +: lldm_pkg::COORD_W]);
    assign in_cy = clamp(s_tdata[lldm_pkg::S_CY_LSB +: lldm_pkg::COORD_W]);
    assign in_sx = clamp(s_tdata[lldm_pkg::S_SX_LSB +: lldm_pkg::COORD_W]);
    assign in_sy = clamp(s_tdata[lldm_pkg::S_SY_LSB +: lldm_pkg::COORD_W]);

    // Shared squarer: dx, dy, root trial and ceiling check in turn
    assign trial = root_reg | (lldm_pkg::ROOT_W'(1) << bit_reg);
    always_comb begin
        case (state_reg)
            ST_SQX:  mul_a = {1'b0, dx_reg};
            ST_SQY:  mul_a = {1'b0, dy_reg};
            ST_ROOT: mul_a = trial;
            default: mul_a = root_reg;
        endcase
    end
    assign mul_p = mul_a * mul_a;

    assign root_inc = {1'b0, root_reg} + (lldm_pkg::ROOT_W + 1)'(1);

    // Single read port on the load registers
    assign rd_idx  = (state_reg == ST_ADD) ? pick_reg : scan_reg[IDX_W-1:0];
    assign rd_load = load_reg[rd_idx];

    // Shared saturating adder: load update or score update
    assign add_a   = (state_reg == ST_ADD) ? rd_load : score_reg;
    assign add_b   = (state_reg == ST_ADD) ? sum_t'(cost_reg) : max_reg;
    assign add_sum = {1'b0, add_a} + {1'b0, add_b};
    assign add_sat = add_sum[lldm_pkg::SUM_W] ? lldm_pkg::SUM_MAX
                                              : add_sum[lldm_pkg::SUM_W-1:0];

    assign scan_live = (scan_reg != CNT_END);
    assign out_free  = !m_valid_reg || m_tready;
    assign pick_ext  = 4'(pick_reg);

    // Sequencer and datapath next state
    always_comb begin
        state_next   = state_reg;
        cid_next     = cid_reg;
        dx_next      = dx_reg;
        dy_next      = dy_reg;
        stop_next    = stop_reg;
        batch_next   = batch_reg;
        sq_next      = sq_reg;
        root_next    = root_reg;
        bit_next     = bit_reg;
        cost_next    = cost_reg;
        scan_next    = scan_reg;
        best_next    = best_reg;
        pick_next    = pick_reg;
        max_next     = max_reg;
        load_next    = load_reg;
        score_next   = score_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        m_last_next  = m_last_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        // Least-load scan runs beside the square root
        if ((state_reg == ST_SQX || state_reg == ST_SQY || state_reg == ST_ROOT ||
             state_reg == ST_CEIL) && scan_live) begin
            if (scan_reg == '0 || rd_load < best_reg) begin
                best_next = rd_load;
                pick_next = scan_reg[IDX_W-1:0];
            end
            scan_next = scan_reg + CNT_W'(1);
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cid_next   = s_tdata[lldm_pkg::S_ID_LSB +: lldm_pkg::ID_W];
                    dx_next    = abs_diff(in_cx, in_sx);
                    dy_next    = abs_diff(in_cy, in_sy);
                    stop_next  = s_tuser;
                    batch_next = s_tlast;
                    scan_next  = '0;
                    state_next = ST_SQX;
                end
            end
            ST_SQX: begin
                sq_next    = mul_p;
                state_next = ST_SQY;
            end
            ST_SQY: begin
                sq_next    = sq_reg + mul_p;
                root_next  = '0;
                bit_next   = lldm_pkg::BIT_W'(lldm_pkg::ROOT_W - 1);
                state_next = ST_ROOT;
            end
            ST_ROOT: begin
                if (mul_p <= sq_reg) begin
                    root_next = trial;
                end
                if (bit_reg == '0) begin
                    state_next = ST_CEIL;
                end else begin
                    bit_next = bit_reg - lldm_pkg::BIT_W'(1);
                end
            end
            ST_CEIL: begin
                // Round up when the floor root falls short; idempotent while waiting
                if (mul_p < sq_reg) begin
                    cost_next = root_inc[lldm_pkg::ROOT_W] ? lldm_pkg::COST_MAX
                                : root_inc[lldm_pkg::COST_W-1:0];
                end else begin
                    cost_next = root_reg;
                end
                if (!scan_live) begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD: begin
                load_next[pick_reg] = add_sat;
                max_next   = '0;
                scan_next  = '0;
                state_next = stop_reg ? ST_MAX : ST_EMIT;
            end
            ST_MAX: begin
                if (scan_live) begin
                    if (rd_load > max_reg) begin
                        max_next = rd_load;
                    end
                    scan_next = scan_reg + CNT_W'(1);
                end else begin
                    for (int k = 0; k < NUM_DRONES; k++) begin
                        load_next[k] = '0;
                    end
                    score_next = add_sat;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_user_next  = stop_reg;
                    m_last_next  = batch_reg;
                    m_data_next  = '0;
                    m_data_next[lldm_pkg::M_ID_LSB +: lldm_pkg::ID_W] = cid_reg;
                    m_data_next[lldm_pkg::M_DRONE_LSB +: lldm_pkg::DRONE_W] =
                        pick_ext[lldm_pkg::DRONE_W-1:0];
                    m_data_next[lldm_pkg::M_COST_LSB +: lldm_pkg::COST_W] = cost_reg;
                    m_data_next[lldm_pkg::M_SPAN_LSB +: lldm_pkg::SUM_W] =
                        stop_reg ? max_reg : '0;
                    m_data_next[lldm_pkg::M_SCORE_LSB +: lldm_pkg::SUM_W] =
                        batch_reg ? score_reg : '0;
                    if (batch_reg) begin
                        score_next = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State, datapath and output registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            score_reg   <= '0;
            scan_reg    <= '0;
            for (int k = 0; k < NUM_DRONES; k++) begin
                load_reg[k] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            score_reg   <= score_next;
            scan_reg    <= scan_next;
            load_reg    <= load_next;
        end
        cid_reg    <= cid_next;
        dx_reg     <= dx_next;
        dy_reg     <= dy_next;
        stop_reg   <= stop_next;
        batch_reg  <= batch_next;
        sq_reg     <= sq_next;
        root_reg   <= root_next;
        bit_reg    <= bit_next;
        cost_reg   <= cost_next;
        best_reg   <= best_next;
        pick_reg   <= pick_next;
        max_reg    <= max_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
        m_last_reg <= m_last_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

endmodule

// ===== src/lldm_checker.sv =====
// Port checker for the least-loaded drone makespan unit.
// Sees the top level's ports only; uses lldm_pkg for the tdata layout.
// Bound into every instance of the top level by the statement at the end.
module lldm_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic [lldm_pkg::S_TDATA_W-1:0] s_tdata,
    input logic                           s_tuser,
    input logic                           s_tlast,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [lldm_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                           m_tuser,
    input logic                           m_tlast,
    input logic                           m_tvalid,
    input logic                           m_tready
);

    // A stalled result holds its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) &&
                                  $stable(m_tuser) && $stable(m_tlast))
        else $error("result changed while stalled");

    // The unit is busy in the cycle after it takes a customer
    a_busy_after_take: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken on consecutive cycles");

    // Makespan is zero unless the result closes a stop
    a_span_only_on_stop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |->
            m_tdata[lldm_pkg::M_SPAN_LSB +: lldm_pkg::SUM_W] == '0)
        else $error("makespan reported outside a stop end");

    // Score is zero unless the result closes the batch
    a_score_only_on_batch: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |->
            m_tdata[lldm_pkg::M_SCORE_LSB +: lldm_pkg::SUM_W] == '0)
        else $error("score reported outside a batch end");

endmodule

bind least_loaded_drone_makespan_unit lldm_checker u_lldm_checker (.*);

// ===== tb/sv/least_loaded_drone_makespan_unit_test.sv =====
// Self-checking testbench for the least-loaded drone makespan unit.
// Drives customers over the input stream and checks every result transfer
// against a local model of the drone loads and score; needs lldm_pkg and the top.
`timescale 1ns / 100ps

module least_loaded_drone_makespan_unit_test;

    localparam int NUM_DRONES      = 3;
    localparam int COORD_LIMIT     = 63;
    localparam int STALL_LIMIT     = 4000;   // cycles without any transfer
    localparam int SETTLE_CYCLES   = 40;     // idle time after the final drain
    localparam int HOLD_OFF_CYCLES = 300;

    typedef struct {
        logic [lldm_pkg::ID_W-1:0]    id;
        logic [lldm_pkg::COORD_W-1:0] cust_x;
        logic [lldm_pkg::COORD_W-1:0] cust_y;
        logic [lldm_pkg::COORD_W-1:0] site_x;
        logic [lldm_pkg::COORD_W-1:0] site_y;
        logic                         stop_end;
        logic                         batch_end;
    } customer_t;

    typedef struct {
        logic [lldm_pkg::ID_W-1:0]    customer;
        logic [lldm_pkg::DRONE_W-1:0] drone;
        logic [lldm_pkg::COST_W-1:0]  cost;
        logic [lldm_pkg::SUM_W-1:0]   makespan;
        logic [lldm_pkg::SUM_W-1:0]   score;
        logic                         stop_done;
        logic                         batch_done;
    } dispatch_t;

    logic                           aclk     = 1'b0;
    logic                           aresetn  = 1'b0;
    logic [lldm_pkg::S_TDATA_W-1:0] s_tdata  = '0;
    logic                           s_tuser  = 1'b0;
    logic                           s_tlast  = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [lldm_pkg::M_TDATA_W-1:0] m_tdata;
    logic                           m_tuser;
    logic                           m_tlast;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;

    // Idle percentages per side, and a forced receiver hold-off
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left     = 0;

    // Model state: per-drone load at the open stop and the running score
    logic [lldm_pkg::SUM_W-1:0] load_by_drone [NUM_DRONES];
    logic [lldm_pkg::SUM_W-1:0] score_running;

    dispatch_t pending_dispatch [$];

    int error_count    = 0;
    int customers_sent = 0;
    int results_seen   = 0;
    int stops_closed   = 0;
    int batches_closed = 0;
    int load_sat_hits  = 0;
    int score_sat_hits = 0;
    int quiet_cycles   = 0;

    least_loaded_drone_makespan_unit #(
        .NUM_DRONES(NUM_DRONES),
        .COORD_MAX (COORD_LIMIT)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .s_tlast (s_tlast),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready)
    );

    always #5 aclk = ~aclk;

    function automatic int unsigned clamped(logic [lldm_pkg::COORD_W-1:0] v);
        return (v > COORD_LIMIT) ? COORD_LIMIT : v;
    endfunction

    // Advance the model by one customer and return the result it should give
    function automatic dispatch_t assign_customer(customer_t c);
        dispatch_t   r;
        int unsigned dx, dy, dist_sq, root, sum, span;
        int          pick;
        dx = (clamped(c.cust_x) >= clamped(c.site_x)) ?
             clamped(c.cust_x) - clamped(c.site_x) : clamped(c.site_x) - clamped(c.cust_x);
        dy = (clamped(c.cust_y) >= clamped(c.site_y)) ?
             clamped(c.cust_y) - clamped(c.site_y) : clamped(c.site_y) - clamped(c.cust_y);
        dist_sq = dx * dx + dy * dy;

        // smallest root whose square covers the distance squared
        root = 0;
        while (root * root < dist_sq) root++;
        if (root > lldm_pkg::COST_MAX) root = lldm_pkg::COST_MAX;

        // least loaded drone, lowest index wins a tie
        pick = 0;
        for (int k = 1; k < NUM_DRONES; k++) begin
            if (load_by_drone[k] < load_by_drone[pick]) pick = k;
        end
        sum = load_by_drone[pick] + root;
        if (sum > lldm_pkg::SUM_MAX) begin
            sum = lldm_pkg::SUM_MAX;
            load_sat_hits++;
        end
        load_by_drone[pick] = sum[lldm_pkg::SUM_W-1:0];

        span = 0;
        if (c.stop_end) begin
            for (int k = 0; k < NUM_DRONES; k++) begin
                if (load_by_drone[k] > span) span = load_by_drone[k];
                load_by_drone[k] = '0;
            end
            sum = score_running + span;
            if (sum > lldm_pkg::SUM_MAX) begin
                sum = lldm_pkg::SUM_MAX;
                score_sat_hits++;
            end
            score_running = sum[lldm_pkg::SUM_W-1:0];
            stops_closed++;
        end

        r.score = '0;
        if (c.batch_end) begin
            r.score       = score_running;
            score_running = '0;
            batches_closed++;
        end

        r.customer   = c.id;
        r.drone      = pick[lldm_pkg::DRONE_W-1:0];
        r.cost       = root[lldm_pkg::COST_W-1:0];
        r.makespan   = span[lldm_pkg::SUM_W-1:0];
        r.stop_done  = c.stop_end;
        r.batch_done = c.batch_end;
        return r;
    endfunction

    function automatic customer_t make_customer(int id, int cx, int cy, int sx, int sy,
                                                bit stop_end, bit batch_end);
        customer_t c;
        c.id        = lldm_pkg::ID_W'(id);
        c.cust_x    = lldm_pkg::COORD_W'(cx);
        c.cust_y    = lldm_pkg::COORD_W'(cy);
        c.site_x    = lldm_pkg::COORD_W'(sx);
        c.site_y    = lldm_pkg::COORD_W'(sy);
        c.stop_end  = stop_end;
        c.batch_end = batch_end;
        return c;
    endfunction

    // Mostly uniform coordinates, with the grid edges favored now and then
    function automatic logic [lldm_pkg::COORD_W-1:0] random_coord();
        if ($urandom_range(9) == 0) return $urandom_range(1) ? '1 : '0;
        return lldm_pkg::COORD_W'($urandom_range(2 ** lldm_pkg::COORD_W - 1));
    endfunction

    function automatic customer_t random_customer(bit stop_end, bit batch_end);
        return make_customer($urandom_range(2 ** lldm_pkg::ID_W - 1), random_coord(),
                             random_coord(), random_coord(), random_coord(),
                             stop_end, batch_end);
    endfunction

    // Offer one customer, idling first at random; returns once it is accepted
    task automatic send_customer(input customer_t c);
        logic [lldm_pkg::S_TDATA_W-1:0] word;
        word = '0;
        word[lldm_pkg::S_ID_LSB +: lldm_pkg::ID_W]    = c.id;
        word[lldm_pkg::S_CX_LSB +: lldm_pkg::COORD_W] = c.cust_x;
        word[lldm_pkg::S_CY_LSB +: lldm_pkg::COORD_W] = c.cust_y;
        word[lldm_pkg::S_SX_LSB +: lldm_pkg::COORD_W] = c.site_x;
        word[lldm_pkg::S_SY_LSB +: lldm_pkg::COORD_W] = c.site_y;
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tdata  <= word;
        s_tuser  <= c.stop_end;
        s_tlast  <= c.batch_end;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        pending_dispatch = {pending_dispatch, assign_customer(c)};
        customers_sent++;
    endtask

    // Stop offering and wait until every expected result has come back
    task automatic wait_for_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_dispatch.size() != 0) @(posedge aclk);
    endtask

    // Corner coordinates, ties, and every combination of stop and batch ends
    task automatic test_directed_corners();
        send_customer(make_customer( 0,  0,  0,  0,  0, 0, 0));  // zero cost
        send_customer(make_customer(63,  0,  0,  0,  0, 0, 0));  // tie on all-zero loads
        send_customer(make_customer( 1, 63, 63,  0,  0, 0, 0));  // longest diagonal
        send_customer(make_customer( 2,  0, 63, 63,  0, 0, 0));
        send_customer(make_customer( 3,  3,  4,  0,  0, 0, 0));  // exact root
        send_customer(make_customer( 4,  0,  0,  1,  1, 1, 0));  // rounded up, stop end
        send_customer(make_customer( 5, 63,  0,  0,  0, 1, 1));  // stop and batch end
        send_customer(make_customer( 6,  0,  0,  0, 63, 0, 1));  // batch end, loads carry
        send_customer(make_customer( 7, 10, 20, 13, 24, 0, 0));
        send_customer(make_customer( 8, 32, 32, 31, 31, 1, 0));
        send_customer(make_customer( 9,  5,  5,  5,  5, 0, 1));
        send_customer(make_customer(42, 63,  0,  0, 63, 1, 0));  // stop that spans a batch end
        send_customer(make_customer(21,  0,  0, 63, 63, 1, 1));
        wait_for_results();
    endtask

    // Receiver holds off while the sender keeps offering, then a full drain
    task automatic test_backpressure();
        hold_left = HOLD_OFF_CYCLES;
        for (int k = 0; k < 8; k++) send_customer(random_customer(k % 3 == 2, k == 7));
        wait_for_results();
    endtask

    // Well-formed batches of stops with random content, plus stray items
    task automatic test_random_batches(input int item_count);
        int sent, stop_count, stop_len;
        sent = 0;
        while (sent < item_count) begin
            if ($urandom_range(99) < 85) begin
                stop_count = $urandom_range(1, 5);
                for (int s = 0; s < stop_count; s++) begin
                    stop_len = $urandom_range(1, 6);
                    for (int k = 0; k < stop_len; k++) begin
                        send_customer(random_customer(k == stop_len - 1,
                                      (s == stop_count - 1) && (k == stop_len - 1)));
                        sent++;
                    end
                end
            end else begin
                send_customer(random_customer($urandom_range(1), $urandom_range(1)));
                sent++;
            end
        end
    endtask

    // One long stop of maximum-cost trips drives every load and then the score
    // into saturation; a short stop after it keeps the score pinned
    task automatic test_sum_saturation();
        for (int k = 0; k < 560; k++) begin
            send_customer(make_customer(k % 64, 63, 63, 0, 0, k == 559, 0));
        end
        send_customer(make_customer(17, 0, 0, 63, 63, 1, 1));
        wait_for_results();
    endtask

    // Receiver side: random ready, or held low during a forced hold-off
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    // Compare each result transfer with the oldest expectation
    always @(posedge aclk) begin : result_check
        dispatch_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (pending_dispatch.size() == 0) begin
                $display("%0t ns: result with nothing expected, tdata 0x%h", $time, m_tdata);
                error_count++;
            end else begin
                want = pending_dispatch.pop_front();
                check_field("assigned_customer", want.customer,
                            m_tdata[lldm_pkg::M_ID_LSB +: lldm_pkg::ID_W]);
                check_field("drone_index", want.drone,
                            m_tdata[lldm_pkg::M_DRONE_LSB +: lldm_pkg::DRONE_W]);
                check_field("trip_cost", want.cost,
                            m_tdata[lldm_pkg::M_COST_LSB +: lldm_pkg::COST_W]);
                check_field("stop_makespan", want.makespan,
                            m_tdata[lldm_pkg::M_SPAN_LSB +: lldm_pkg::SUM_W]);
                check_field("total_score", want.score,
                            m_tdata[lldm_pkg::M_SCORE_LSB +: lldm_pkg::SUM_W]);
                check_field("pad", 0, m_tdata[lldm_pkg::M_TDATA_W-1:lldm_pkg::M_USED_W]);
                check_field("stop_done", want.stop_done, m_tuser);
                check_field("batch_done", want.batch_done, m_tlast);
            end
        end
    end

    // Watchdog on cycles with no transfer on either side
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
        else quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t ns: no transfer for %0d cycles, %0d results outstanding",
                     $time, quiet_cycles, pending_dispatch.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        foreach (load_by_drone[k]) load_by_drone[k] = '0;
        score_running = '0;
        send_idle_pct = 33;
        recv_idle_pct = 73;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed_corners();
        test_backpressure();
        test_random_batches(75);

        send_idle_pct = 73;
        recv_idle_pct = 33;
        test_random_batches(75);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_sum_saturation();
        test_random_batches(75);

        @(negedge aclk);
        s_tvalid <= 1'b0;
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("Covered %0d customers over %0d stops and %0d batches; %0d results checked.",
                 customers_sent, stops_closed, batches_closed, results_seen);
        $display("Saturated sums: %0d drone loads, %0d scores; %0d mismatches.",
                 load_sat_hits, score_sat_hits, error_count);
        if (error_count == 0 && pending_dispatch.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
